>>> sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled during reset
`define RBST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, disabled during reset
`define RBST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RBST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RBST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/rbst_pkg.sv
// shared types and constants of the ray box slab test
`default_nettype none
package rbst_pkg;
    localparam int Q_W          = 32;
    localparam int DIFF_W       = Q_W + 1;
    localparam int PROD_W       = DIFF_W + Q_W;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_AXES     = 3;
    localparam int NUM_LANES    = 2 * NUM_AXES;
    localparam int LANE_LAT     = 3;
    localparam int MERGE_LAT    = 2;
    localparam int LATENCY      = LANE_LAT + MERGE_LAT;

    localparam logic signed [Q_W-1:0] Q_MAX       = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN       = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [Q_W-1:0] INV_POS_INF = Q_MAX;
    localparam logic signed [Q_W-1:0] INV_NEG_INF = Q_MIN;

    typedef logic signed [Q_W-1:0] t_q;

    typedef struct packed {
        logic valid;
        logic hit;
        t_q   entry;
        t_q   exit_d;
    } t_result;
endpackage
`default_nettype wire

>>> sv/rbst_lane.sv
// one slab distance lane: difference, product, floor shift and saturation
`default_nettype none
module rbst_lane #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire rbst_pkg::t_q i_corner,
    input  wire rbst_pkg::t_q i_origin,
    input  wire rbst_pkg::t_q i_inv,
    output rbst_pkg::t_q      o_dist
);
    localparam int DW = rbst_pkg::DIFF_W;
    localparam int PW = rbst_pkg::PROD_W;
    localparam int QW = rbst_pkg::Q_W;

    // stage 1
    logic signed [DW-1:0] r_diff;
    rbst_pkg::t_q         r_inv;
    logic                 r_inf1;
    // stage 2
    logic signed [PW-1:0] r_prod;
    logic                 r_inf2;
    rbst_pkg::t_q         r_inf_val;
    // stage 3
    rbst_pkg::t_q         r_dist;

    logic signed [DW-1:0] n_diff;
    rbst_pkg::t_q         n_inf_val;
    logic signed [PW-1:0] n_shift;
    rbst_pkg::t_q         n_dist;
    logic                 n_ovf;

    assign n_diff = {i_corner[QW-1], i_corner} - {i_origin[QW-1], i_origin};

    // infinite inverse: sign of difference times infinity
    always_comb begin
        if (r_diff == '0) begin
            n_inf_val = '0;
        end else if (r_diff[DW-1] == r_inv[QW-1]) begin
            n_inf_val = rbst_pkg::Q_MAX;
        end else begin
            n_inf_val = rbst_pkg::Q_MIN;
        end
    end

    // floor shift, then saturate when the high bits are not a sign extension
    always_comb begin
        n_shift = r_prod >>> FRAC_BITS;
        n_ovf   = !((&n_shift[PW-1:QW-1]) || !(|n_shift[PW-1:QW-1]));
        if (r_inf2) begin
            n_dist = r_inf_val;
        end else if (n_ovf) begin
            n_dist = n_shift[PW-1] ? rbst_pkg::Q_MIN : rbst_pkg::Q_MAX;
        end else begin
            n_dist = n_shift[QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff    <= n_diff;
        r_inv     <= i_inv;
        r_inf1    <= (i_inv == rbst_pkg::INV_POS_INF) || (i_inv == rbst_pkg::INV_NEG_INF);
        r_prod    <= r_diff * r_inv;
        r_inf2    <= r_inf1;
        r_inf_val <= n_inf_val;
        r_dist    <= n_dist;
    end

    assign o_dist = r_dist;
endmodule
`default_nettype wire

>>> sv/rbst_merge.sv
// merges the six lane distances into the entry/exit interval and hit flag
`default_nettype none
module rbst_merge (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire rbst_pkg::t_q      i_dist [rbst_pkg::NUM_LANES],
    output rbst_pkg::t_result      o_res
);
    localparam int NA = rbst_pkg::NUM_AXES;

    logic              r_vld;
    rbst_pkg::t_q      r_near [NA];
    rbst_pkg::t_q      r_far  [NA];
    rbst_pkg::t_result r_res;

    rbst_pkg::t_q      n_near [NA];
    rbst_pkg::t_q      n_far  [NA];
    rbst_pkg::t_q      n_near_all;
    rbst_pkg::t_q      n_far_all;
    logic              n_hit;

    // per axis: smaller distance enters, larger exits
    always_comb begin
        for (int a = 0; a < NA; a++) begin
            if (i_dist[a] < i_dist[a+NA]) begin
                n_near[a] = i_dist[a];
                n_far[a]  = i_dist[a+NA];
            end else begin
                n_near[a] = i_dist[a+NA];
                n_far[a]  = i_dist[a];
            end
        end
    end

    // narrowing only shrinks the interval, so the final check covers every axis
    always_comb begin
        n_near_all = r_near[0];
        n_far_all  = r_far[0];
        for (int a = 1; a < NA; a++) begin
            if (r_near[a] > n_near_all) n_near_all = r_near[a];
            if (r_far[a] < n_far_all)   n_far_all  = r_far[a];
        end
        n_hit = (n_near_all <= n_far_all) && !n_far_all[rbst_pkg::Q_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= 1'b0;
            r_res.valid <= 1'b0;
        end else begin
            r_vld       <= i_vld;
            r_res.valid <= r_vld;
        end
        r_near       <= n_near;
        r_far        <= n_far;
        r_res.hit    <= n_hit;
        r_res.entry  <= n_hit ? n_near_all : '0;
        r_res.exit_d <= n_hit ? n_far_all : '0;
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

>>> sv/ray_box_slab_test.sv
// top level of the ray versus axis-aligned box slab test
// A ray/box test in signed fixed point (FRAC_BITS fraction bits, Q16.16 by
// default). Each request carries the box min and max corners, the ray origin
// and the inverse ray direction; an inverse of 0x7fffffff or 0x80000000 is
// taken as plus or minus infinity. The block is fully pipelined: busy is
// never raised, a request is taken every cycle that start is high, and its
// result appears on the o_ ports with o_valid high after passing through
// 3 lane stages (difference, multiply, shift and saturate) and 2 merge stages
// (per-axis ordering, then interval narrowing). The receiver cannot stall, so
// o_valid lasts one cycle and must be captured at once. On a miss o_hit is
// low and both distances read 0.
`default_nettype none
`include "assert_macros.svh"
module ray_box_slab_test #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire rbst_pkg::t_q i_box_min_x,
    input  wire rbst_pkg::t_q i_box_min_y,
    input  wire rbst_pkg::t_q i_box_min_z,
    input  wire rbst_pkg::t_q i_box_max_x,
    input  wire rbst_pkg::t_q i_box_max_y,
    input  wire rbst_pkg::t_q i_box_max_z,
    input  wire rbst_pkg::t_q i_origin_x,
    input  wire rbst_pkg::t_q i_origin_y,
    input  wire rbst_pkg::t_q i_origin_z,
    input  wire rbst_pkg::t_q i_inv_dir_x,
    input  wire rbst_pkg::t_q i_inv_dir_y,
    input  wire rbst_pkg::t_q i_inv_dir_z,
    output logic              o_valid,
    output logic              o_hit,
    output rbst_pkg::t_q      o_entry_distance,
    output rbst_pkg::t_q      o_exit_distance
);
    localparam int NA = rbst_pkg::NUM_AXES;
    localparam int NL = rbst_pkg::NUM_LANES;
    localparam int LL = rbst_pkg::LANE_LAT;

    // lanes 0..2 take the min corners, lanes 3..5 the max corners
    rbst_pkg::t_q      w_corner [NL];
    rbst_pkg::t_q      w_origin [NA];
    rbst_pkg::t_q      w_inv    [NA];
    rbst_pkg::t_q      w_dist   [NL];
    rbst_pkg::t_result w_res;

    // request valid travels alongside the lane pipeline
    logic [LL-1:0]     r_vld;
    logic              n_accept;

    assign busy     = 1'b0;
    assign n_accept = start && !busy;

    assign w_corner[0] = i_box_min_x;
    assign w_corner[1] = i_box_min_y;
    assign w_corner[2] = i_box_min_z;
    assign w_corner[3] = i_box_max_x;
    assign w_corner[4] = i_box_max_y;
    assign w_corner[5] = i_box_max_z;
    assign w_origin[0] = i_origin_x;
    assign w_origin[1] = i_origin_y;
    assign w_origin[2] = i_origin_z;
    assign w_inv[0]    = i_inv_dir_x;
    assign w_inv[1]    = i_inv_dir_y;
    assign w_inv[2]    = i_inv_dir_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LL-2:0], n_accept};
        end
    end

    // six slab distance lanes side by side
    for (genvar l = 0; l < NL; l++) begin : g_lane
        rbst_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_corner (w_corner[l]),
            .i_origin (w_origin[l % NA]),
            .i_inv    (w_inv[l % NA]),
            .o_dist   (w_dist[l])
        );
    end

    // interval narrowing and hit decision
    rbst_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[LL-1]),
        .i_dist  (w_dist),
        .o_res   (w_res)
    );

    assign o_valid          = w_res.valid;
    assign o_hit            = w_res.hit;
    assign o_entry_distance = w_res.entry;
    assign o_exit_distance  = w_res.exit_d;

    // every result traces back to a request taken a fixed latency earlier
    `RBST_ASSERT_IMP(a_result_has_request, i_clk, i_rst_n, o_valid,
        $past(start, rbst_pkg::LATENCY))
    // a miss reports a zero interval
    `RBST_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_valid && !o_hit,
        (o_entry_distance == '0) && (o_exit_distance == '0))
    // a hit reports an ordered interval that ends ahead of the origin
    `RBST_ASSERT_IMP(a_hit_interval, i_clk, i_rst_n, o_valid && o_hit,
        (o_entry_distance <= o_exit_distance) && !o_exit_distance[rbst_pkg::Q_W-1])
    // a taken request is in flight the next cycle
    `RBST_ASSERT_NXT(a_request_tracked, i_clk, i_rst_n, start && !busy, r_vld[0])
endmodule
`default_nettype wire
